// ===== rtl/tcpse_pkg.sv =====
// -----------------------------------------------------------------------------
// tcpse_pkg: shared types and constants of the TCP connection state engine
// Connection states, operation and result codes, flag masks and the command
// record that travels from the front end to the engine.
// -----------------------------------------------------------------------------
package tcpse_pkg;

   // table size
   localparam int CONN_NUM = 4;
   localparam int IDX_W    = $clog2(CONN_NUM);

   // segment flag bits
   localparam logic [5:0] FL_ACK = 6'h10;
   localparam logic [5:0] FL_PSH = 6'h08;
   localparam logic [5:0] FL_RST = 6'h04;
   localparam logic [5:0] FL_SYN = 6'h02;
   localparam logic [5:0] FL_FIN = 6'h01;
   localparam logic [5:0] FL_SEG_MASK = FL_SYN | FL_ACK | FL_RST | FL_FIN;

   // configuration register indexes
   localparam logic [1:0] CSR_LOCAL_IP   = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd1;
   localparam logic [1:0] CSR_REXMIT_EN  = 2'd2;
   localparam logic [1:0] CSR_REXMIT_LIM = 2'd3;

   // plan bits, emitted lowest first
   localparam int P_DELIVER   = 0;
   localparam int P_READ_PRE  = 1;
   localparam int P_XMIT      = 2;
   localparam int P_READ_POST = 3;
   localparam int P_CLOSED    = 4;

   typedef enum logic [1:0] {
      OP_SEG  = 2'd0,
      OP_OPEN = 2'd1,
      OP_SEND = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CS_CLOSED   = 3'd0,
      CS_SYN_SENT = 3'd1,
      CS_SYN_RCVD = 3'd2,
      CS_ESTAB    = 3'd3,
      CS_FIN_WAIT = 3'd4
   } conn_state_type;

   typedef enum logic [2:0] {
      K_DONE    = 3'd0,
      K_SEGMENT = 3'd1,
      K_DELIVER = 3'd2,
      K_READ    = 3'd3,
      K_CLOSED  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      E_IDLE,
      E_SEG_LOOK,
      E_SEG_EVAL,
      E_OPEN,
      E_SEND,
      E_TICK_EVAL,
      E_EMIT,
      E_DONE
   } eng_state_type;

   // classified transaction
   typedef struct packed {
      op_type             op;
      logic               dst_hit;
      logic [31:0]        now;
      logic [31:0]        src_addr;
      logic [15:0]        src_port;
      logic [15:0]        dst_port;
      logic [5:0]         flags;
      logic [31:0]        seq;
      logic [31:0]        ack;
      logic [15:0]        len;
      logic [IDX_W-1:0]   conn_id;
   } cmd_type;

endpackage

// ===== rtl/tcpse_front.sv =====
// -----------------------------------------------------------------------------
// tcpse_front: request intake
// Decodes the operation, checks the destination address and masks the flags
// of received segments, then hands the command to the queue.
// -----------------------------------------------------------------------------
module tcpse_front
   import tcpse_pkg::*;
(
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_opcode,
   input  logic [31:0]  req_now_ms,
   input  logic [31:0]  req_dst_addr,
   input  logic [31:0]  req_src_addr,
   input  logic [15:0]  req_src_port,
   input  logic [15:0]  req_dst_port,
   input  logic [5:0]   req_seg_flags,
   input  logic [31:0]  req_seg_seq,
   input  logic [31:0]  req_seg_ack,
   input  logic [15:0]  req_payload_len,
   input  logic [1:0]   req_conn_id,
   input  logic [31:0]  local_ip,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_wdata
);

   // classify
   always_comb begin
      q_wdata.op       = op_type'(req_opcode);
      q_wdata.dst_hit  = (req_dst_addr == local_ip);
      q_wdata.now      = req_now_ms;
      q_wdata.src_addr = req_src_addr;
      q_wdata.src_port = req_src_port;
      q_wdata.dst_port = req_dst_port;
      q_wdata.flags    = (op_type'(req_opcode) == OP_SEG) ? (req_seg_flags & FL_SEG_MASK)
                                                          : req_seg_flags;
      q_wdata.seq      = req_seg_seq;
      q_wdata.ack      = req_seg_ack;
      q_wdata.len      = req_payload_len;
      q_wdata.conn_id  = req_conn_id[IDX_W-1:0];
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== rtl/tcpse_queue.sv =====
// -----------------------------------------------------------------------------
// tcpse_queue: two-entry command queue
// Decouples the front end from the engine.
// -----------------------------------------------------------------------------
module tcpse_queue
   import tcpse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  wdata,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output cmd_type  rdata
);

   cmd_type      mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign rdata = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/tcpse_engine.sv =====
// -----------------------------------------------------------------------------
// tcpse_engine: connection table and sequencer
// Carries out one command at a time: lookup, state update, then emits the
// planned results one per cycle through the output register unless stalled, then done.
// -----------------------------------------------------------------------------
module tcpse_engine
   import tcpse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_type       cmd,
   output logic          q_pop,
   input  logic [15:0]   timeout_ms,
   input  logic          rexmit_en,
   input  logic [2:0]    rexmit_lim,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_kind,
   output logic [1:0]    rsp_conn_index,
   output logic [5:0]    rsp_out_flags,
   output logic [31:0]   rsp_out_seq,
   output logic [31:0]   rsp_out_ack,
   output logic [15:0]   rsp_out_len,
   output logic [31:0]   rsp_peer_addr,
   output logic [15:0]   rsp_peer_port,
   output logic [15:0]   rsp_own_port,
   output logic          rsp_aux_flag,
   output logic          rsp_last
);

   // connection table
   conn_state_type  status_ff [CONN_NUM];
   conn_state_type  status_in [CONN_NUM];
   logic [31:0]     event_ff  [CONN_NUM];
   logic [31:0]     event_in  [CONN_NUM];
   logic [31:0]     snd_ff    [CONN_NUM];
   logic [31:0]     snd_in    [CONN_NUM];
   logic [31:0]     rcv_ff    [CONN_NUM];
   logic [31:0]     rcv_in    [CONN_NUM];
   logic [31:0]     saved_ff  [CONN_NUM];
   logic [31:0]     saved_in  [CONN_NUM];
   logic [31:0]     rip_ff    [CONN_NUM];
   logic [31:0]     rip_in    [CONN_NUM];
   logic [15:0]     rport_ff  [CONN_NUM];
   logic [15:0]     rport_in  [CONN_NUM];
   logic [15:0]     lport_ff  [CONN_NUM];
   logic [15:0]     lport_in  [CONN_NUM];
   logic [2:0]      retry_ff  [CONN_NUM];
   logic [2:0]      retry_in  [CONN_NUM];
   logic            cack_ff   [CONN_NUM];
   logic            cack_in   [CONN_NUM];

   // sequencer
   eng_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  id_ff, id_in;
   logic [4:0]        plan_ff, plan_in;
   logic [5:0]        xfl_ff, xfl_in;
   logic [15:0]       xlen_ff, xlen_in;
   logic [15:0]       dlen_ff, dlen_in;
   logic              read_aux_ff, read_aux_in;
   logic              close_aux_ff, close_aux_in;
   logic [IDX_W-1:0]  done_idx_ff, done_idx_in;
   logic              done_aux_ff, done_aux_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic [IDX_W-1:0]  cidx_ff, cidx_in;
   logic [5:0]        oflags_ff, oflags_in;
   logic [31:0]       oseq_ff, oseq_in;
   logic [31:0]       oack_ff, oack_in;
   logic [15:0]       olen_ff, olen_in;
   logic [31:0]       paddr_ff, paddr_in;
   logic [15:0]       pport_ff, pport_in;
   logic [15:0]       lport_o_ff, lport_o_in;
   logic              aux_ff, aux_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              out_load;
   logic              match_found, free_found;
   logic [IDX_W-1:0]  match_idx, free_idx;
   logic [31:0]       isn;

   // parallel lookup over the table
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      free_found  = 1'b0;
      free_idx    = '0;
      for (int i = CONN_NUM - 1; i >= 0; i--) begin
         if (status_ff[i] != CS_CLOSED && rip_ff[i] == cmd.src_addr &&
             rport_ff[i] == cmd.src_port && lport_ff[i] == cmd.dst_port) begin
            match_found = 1'b1;
            match_idx   = IDX_W'(i);
         end
         if (status_ff[i] == CS_CLOSED) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign isn = cmd.now + {cmd.now[15:0], 16'h0000};

   // next state and datapath
   always_comb begin
      status_in    = status_ff;
      event_in     = event_ff;
      snd_in       = snd_ff;
      rcv_in       = rcv_ff;
      saved_in     = saved_ff;
      rip_in       = rip_ff;
      rport_in     = rport_ff;
      lport_in     = lport_ff;
      retry_in     = retry_ff;
      cack_in      = cack_ff;
      state_in     = state_ff;
      id_in        = id_ff;
      plan_in      = plan_ff;
      xfl_in       = xfl_ff;
      xlen_in      = xlen_ff;
      dlen_in      = dlen_ff;
      read_aux_in  = read_aux_ff;
      close_aux_in = close_aux_ff;
      done_idx_in  = done_idx_ff;
      done_aux_in  = done_aux_ff;
      kind_in      = kind_ff;
      cidx_in      = cidx_ff;
      oflags_in    = oflags_ff;
      oseq_in      = oseq_ff;
      oack_in      = oack_ff;
      olen_in      = olen_ff;
      paddr_in     = paddr_ff;
      pport_in     = pport_ff;
      lport_o_in   = lport_o_ff;
      aux_in       = aux_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         E_IDLE: begin
            if (q_valid) begin
               plan_in     = '0;
               done_idx_in = '0;
               done_aux_in = 1'b0;
               id_in       = '0;
               case (cmd.op)
                  OP_SEG:  state_in = cmd.dst_hit ? E_SEG_LOOK : E_DONE;
                  OP_OPEN: state_in = E_OPEN;
                  OP_SEND: state_in = E_SEND;
                  default: state_in = E_TICK_EVAL;
               endcase
            end
         end

         // find the connection, or take a free slot for a bare SYN
         E_SEG_LOOK: begin
            if (match_found) begin
               id_in    = match_idx;
               state_in = E_SEG_EVAL;
            end else if (cmd.flags == FL_SYN && free_found) begin
               status_in[free_idx] = CS_SYN_RCVD;
               event_in[free_idx]  = cmd.now;
               snd_in[free_idx]    = isn;
               saved_in[free_idx]  = isn;
               rcv_in[free_idx]    = cmd.seq + 32'd1;
               rip_in[free_idx]    = cmd.src_addr;
               rport_in[free_idx]  = cmd.src_port;
               lport_in[free_idx]  = cmd.dst_port;
               cack_in[free_idx]   = 1'b0;
               retry_in[free_idx]  = 3'd0;
               id_in               = free_idx;
               xfl_in              = FL_SYN | FL_ACK;
               xlen_in             = 16'd0;
               plan_in[P_XMIT]     = 1'b1;
               state_in            = E_EMIT;
            end else begin
               state_in = E_DONE;
            end
         end

         // segment on a known connection
         E_SEG_EVAL: begin
            dlen_in      = cmd.len;
            xlen_in      = 16'd0;
            read_aux_in  = 1'b0;
            close_aux_in = 1'b0;
            if ((cmd.flags & FL_RST) != '0) begin
               if (status_ff[id_ff] == CS_ESTAB || status_ff[id_ff] == CS_FIN_WAIT) begin
                  plan_in[P_CLOSED] = 1'b1;
                  close_aux_in      = 1'b1;
               end
               status_in[id_ff] = CS_CLOSED;
               state_in         = E_EMIT;
            end else if (cmd.seq != rcv_ff[id_ff] || cmd.ack != snd_ff[id_ff] ||
                         (cmd.flags & FL_ACK) == '0) begin
               state_in = E_DONE;
            end else begin
               saved_in[id_ff] = snd_ff[id_ff];
               retry_in[id_ff] = 3'd0;
               rcv_in[id_ff]   = rcv_ff[id_ff] + {16'h0000, cmd.len} +
                                 {31'd0, (cmd.flags & (FL_FIN | FL_SYN)) != '0};
               event_in[id_ff] = cmd.now;
               state_in        = E_EMIT;
               case (status_ff[id_ff])
                  CS_SYN_SENT: begin
                     if (cmd.flags != (FL_SYN | FL_ACK)) begin
                        status_in[id_ff] = CS_CLOSED;
                     end else begin
                        xfl_in               = FL_ACK;
                        plan_in[P_XMIT]      = 1'b1;
                        plan_in[P_READ_POST] = 1'b1;
                        status_in[id_ff]     = CS_ESTAB;
                     end
                  end
                  CS_SYN_RCVD: begin
                     if (cmd.flags != FL_ACK) begin
                        status_in[id_ff] = CS_CLOSED;
                     end else begin
                        plan_in[P_READ_PRE] = 1'b1;
                        status_in[id_ff]    = CS_ESTAB;
                     end
                  end
                  CS_ESTAB: begin
                     if (cmd.flags == (FL_FIN | FL_ACK)) begin
                        plan_in[P_DELIVER] = (cmd.len != 16'd0);
                        xfl_in             = FL_FIN | FL_ACK;
                        plan_in[P_XMIT]    = 1'b1;
                        plan_in[P_CLOSED]  = 1'b1;
                        status_in[id_ff]   = CS_CLOSED;
                     end else if (cmd.flags == FL_ACK) begin
                        plan_in[P_DELIVER]  = (cmd.len != 16'd0);
                        plan_in[P_READ_PRE] = 1'b1;
                        xfl_in              = FL_ACK;
                        plan_in[P_XMIT]     = (cmd.len != 16'd0);
                     end
                  end
                  CS_FIN_WAIT: begin
                     if (cmd.flags == (FL_FIN | FL_ACK)) begin
                        plan_in[P_DELIVER] = (cmd.len != 16'd0);
                        xfl_in             = FL_ACK;
                        plan_in[P_XMIT]    = 1'b1;
                        plan_in[P_CLOSED]  = 1'b1;
                        status_in[id_ff]   = CS_CLOSED;
                     end else if (cmd.flags == FL_ACK && cmd.len != 16'd0) begin
                        plan_in[P_DELIVER] = 1'b1;
                        xfl_in             = FL_ACK;
                        plan_in[P_XMIT]    = 1'b1;
                        cack_in[id_ff]     = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // active open
         E_OPEN: begin
            if (free_found) begin
               status_in[free_idx] = CS_SYN_SENT;
               event_in[free_idx]  = cmd.now;
               snd_in[free_idx]    = isn;
               saved_in[free_idx]  = isn;
               rcv_in[free_idx]    = 32'd0;
               rip_in[free_idx]    = cmd.src_addr;
               rport_in[free_idx]  = cmd.src_port;
               lport_in[free_idx]  = cmd.dst_port;
               cack_in[free_idx]   = 1'b0;
               retry_in[free_idx]  = 3'd0;
               id_in               = free_idx;
               done_idx_in         = free_idx;
               xfl_in              = FL_SYN;
               xlen_in             = 16'd0;
               plan_in[P_XMIT]     = 1'b1;
               state_in            = E_EMIT;
            end else begin
               done_aux_in = 1'b1;
               state_in    = E_DONE;
            end
         end

         // application send
         E_SEND: begin
            id_in = cmd.conn_id;
            if (status_ff[cmd.conn_id] == CS_ESTAB) begin
               xfl_in  = FL_ACK | (cmd.flags & FL_PSH) | (cmd.flags & FL_FIN);
               xlen_in = cmd.len;
               if ((cmd.flags & FL_FIN) != '0) begin
                  status_in[cmd.conn_id] = CS_FIN_WAIT;
               end
               plan_in[P_XMIT] = 1'b1;
               state_in        = E_EMIT;
            end else begin
               state_in = E_DONE;
            end
         end

         // timer walk, one entry per visit
         E_TICK_EVAL: begin
            read_aux_in  = 1'b1;
            close_aux_in = 1'b1;
            xlen_in      = 16'd0;
            if (status_ff[id_ff] == CS_CLOSED ||
                (cmd.now - event_ff[id_ff]) <= {16'h0000, timeout_ms}) begin
               if (id_ff == IDX_W'(CONN_NUM - 1)) begin
                  state_in = E_DONE;
               end else begin
                  id_in = id_ff + 1'b1;
               end
            end else if (!rexmit_en || retry_ff[id_ff] > rexmit_lim) begin
               status_in[id_ff]  = CS_CLOSED;
               plan_in[P_CLOSED] = 1'b1;
               state_in          = E_EMIT;
            end else begin
               event_in[id_ff] = cmd.now;
               if (retry_ff[id_ff] != 3'd7) begin
                  retry_in[id_ff] = retry_ff[id_ff] + 3'd1;
               end
               snd_in[id_ff]   = saved_ff[id_ff];
               plan_in[P_XMIT] = 1'b1;
               state_in        = E_EMIT;
               case (status_ff[id_ff])
                  CS_SYN_SENT: xfl_in = FL_SYN;
                  CS_SYN_RCVD: xfl_in = FL_SYN | FL_ACK;
                  CS_FIN_WAIT: begin
                     xfl_in = FL_ACK;
                     if (!cack_ff[id_ff]) begin
                        status_in[id_ff]    = CS_ESTAB;
                        plan_in[P_READ_PRE] = 1'b1;
                     end
                  end
                  default: begin
                     xfl_in              = FL_ACK;
                     plan_in[P_READ_PRE] = 1'b1;
                  end
               endcase
            end
         end

         // emit planned results in order
         E_EMIT: begin
            if (plan_ff == '0) begin
               if (cmd.op == OP_TICK && id_ff != IDX_W'(CONN_NUM - 1)) begin
                  id_in    = id_ff + 1'b1;
                  state_in = E_TICK_EVAL;
               end else begin
                  state_in = E_DONE;
               end
            end else if (out_free) begin
               out_load   = 1'b1;
               cidx_in    = id_ff;
               oflags_in  = '0;
               oseq_in    = '0;
               oack_in    = '0;
               olen_in    = '0;
               aux_in     = 1'b0;
               last_in    = 1'b0;
               paddr_in   = rip_ff[id_ff];
               pport_in   = rport_ff[id_ff];
               lport_o_in = lport_ff[id_ff];
               if (plan_ff[P_DELIVER]) begin
                  kind_in            = K_DELIVER;
                  olen_in            = dlen_ff;
                  plan_in[P_DELIVER] = 1'b0;
               end else if (plan_ff[P_READ_PRE]) begin
                  kind_in             = K_READ;
                  aux_in              = read_aux_ff;
                  plan_in[P_READ_PRE] = 1'b0;
               end else if (plan_ff[P_XMIT]) begin
                  kind_in         = K_SEGMENT;
                  oflags_in       = xfl_ff;
                  oseq_in         = snd_ff[id_ff];
                  oack_in         = rcv_ff[id_ff];
                  olen_in         = xlen_ff;
                  snd_in[id_ff]   = snd_ff[id_ff] + {16'h0000, xlen_ff} +
                                    {31'd0, (xfl_ff & (FL_SYN | FL_FIN)) != '0};
                  plan_in[P_XMIT] = 1'b0;
               end else if (plan_ff[P_READ_POST]) begin
                  kind_in              = K_READ;
                  aux_in               = read_aux_ff;
                  plan_in[P_READ_POST] = 1'b0;
               end else begin
                  kind_in           = K_CLOSED;
                  aux_in            = close_aux_ff;
                  plan_in[P_CLOSED] = 1'b0;
               end
            end
         end

         // closing done item
         E_DONE: begin
            if (out_free) begin
               out_load   = 1'b1;
               kind_in    = K_DONE;
               cidx_in    = done_idx_ff;
               oflags_in  = '0;
               oseq_in    = '0;
               oack_in    = '0;
               olen_in    = '0;
               paddr_in   = '0;
               pport_in   = '0;
               lport_o_in = '0;
               aux_in     = done_aux_ff;
               last_in    = 1'b1;
               q_pop      = 1'b1;
               state_in   = E_IDLE;
            end
         end

         default: state_in = E_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         plan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CONN_NUM; i++) begin
            status_ff[i] <= CS_CLOSED;
            event_ff[i]  <= '0;
            retry_ff[i]  <= '0;
            cack_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         plan_ff      <= plan_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         event_ff     <= event_in;
         retry_ff     <= retry_in;
         cack_ff      <= cack_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      snd_ff       <= snd_in;
      rcv_ff       <= rcv_in;
      saved_ff     <= saved_in;
      rip_ff       <= rip_in;
      rport_ff     <= rport_in;
      lport_ff     <= lport_in;
      id_ff        <= id_in;
      xfl_ff       <= xfl_in;
      xlen_ff      <= xlen_in;
      dlen_ff      <= dlen_in;
      read_aux_ff  <= read_aux_in;
      close_aux_ff <= close_aux_in;
      done_idx_ff  <= done_idx_in;
      done_aux_ff  <= done_aux_in;
      kind_ff      <= kind_in;
      cidx_ff      <= cidx_in;
      oflags_ff    <= oflags_in;
      oseq_ff      <= oseq_in;
      oack_ff      <= oack_in;
      olen_ff      <= olen_in;
      paddr_ff     <= paddr_in;
      pport_ff     <= pport_in;
      lport_o_ff   <= lport_o_in;
      aux_ff       <= aux_in;
      last_ff      <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_conn_index = 2'(cidx_ff);
   assign rsp_out_flags  = oflags_ff;
   assign rsp_out_seq    = oseq_ff;
   assign rsp_out_ack    = oack_ff;
   assign rsp_out_len    = olen_ff;
   assign rsp_peer_addr  = paddr_ff;
   assign rsp_peer_port  = pport_ff;
   assign rsp_own_port   = lport_o_ff;
   assign rsp_aux_flag   = aux_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTH
   a_last_only_at_done: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_in) |-> (state_ff == E_DONE))
      else $error("final result loaded outside done state");

   a_pop_at_done: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == E_DONE && out_free))
      else $error("queue popped before done item left");

   a_idle_no_plan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_IDLE) |-> (plan_ff == '0))
      else $error("pending results while idle");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_out_seq)))
      else $error("output register overwritten while stalled");
`endif

endmodule

// ===== rtl/tcp_connection_state_engine.sv =====
// -----------------------------------------------------------------------------
// tcp_connection_state_engine: small TCP connection table and state engine
// Front end, two-entry command queue, sequencing engine and register file.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per operation (segment, open, send, tick);
//   it is taken when req_valid is high and req_stall low. rsp_* returns the
//   result transactions of each operation in order, the last one being a done
//   item with rsp_last set. csr_* writes the four configuration registers;
//   write only while the block is idle.
// Sequencing:
//   Operations run one at a time in the engine; a rejected operation has
//   done as its only result. A tick visits every table entry in turn. The
//   queue holds the running operation and takes one further request.
// Reset:
//   Synchronous, active high. Every connection is closed, timers and retry
//   counts cleared, registers at their defaults, queue and output empty.
// Stall:
//   While rsp_stall is high the output register holds; the engine waits and
//   the queue fills, after which req_stall rises.
// -----------------------------------------------------------------------------
module tcp_connection_state_engine
   import tcpse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_opcode,
   input  logic [31:0]  req_now_ms,
   input  logic [31:0]  req_dst_addr,
   input  logic [31:0]  req_src_addr,
   input  logic [15:0]  req_src_port,
   input  logic [15:0]  req_dst_port,
   input  logic [5:0]   req_seg_flags,
   input  logic [31:0]  req_seg_seq,
   input  logic [31:0]  req_seg_ack,
   input  logic [15:0]  req_payload_len,
   input  logic         req_accept_ok,
   input  logic [1:0]   req_conn_id,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_kind,
   output logic [1:0]   rsp_conn_index,
   output logic [5:0]   rsp_out_flags,
   output logic [31:0]  rsp_out_seq,
   output logic [31:0]  rsp_out_ack,
   output logic [15:0]  rsp_out_len,
   output logic [31:0]  rsp_peer_addr,
   output logic [15:0]  rsp_peer_port,
   output logic [15:0]  rsp_own_port,
   output logic         rsp_aux_flag,
   output logic         rsp_last,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [31:0]  local_ip_ff;
   logic [15:0]  timeout_ff;
   logic         rexmit_en_ff;
   logic [2:0]   rexmit_lim_ff;

   logic         q_push, q_full, q_pop, q_valid;
   cmd_type      q_wdata, q_rdata;
   logic         accept_ok_unused;

   // accept_ok carries no meaning
   assign accept_ok_unused = req_accept_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff   <= 32'd0;
         timeout_ff    <= 16'd1000;
         rexmit_en_ff  <= 1'b1;
         rexmit_lim_ff <= 3'd5;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOCAL_IP:   local_ip_ff   <= csr_wdata;
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata[15:0];
            CSR_REXMIT_EN:  rexmit_en_ff  <= csr_wdata[0];
            CSR_REXMIT_LIM: rexmit_lim_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   tcpse_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_now_ms      (req_now_ms),
      .req_dst_addr    (req_dst_addr),
      .req_src_addr    (req_src_addr),
      .req_src_port    (req_src_port),
      .req_dst_port    (req_dst_port),
      .req_seg_flags   (req_seg_flags),
      .req_seg_seq     (req_seg_seq),
      .req_seg_ack     (req_seg_ack),
      .req_payload_len (req_payload_len),
      .req_conn_id     (req_conn_id),
      .local_ip        (local_ip_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_wdata         (q_wdata)
   );

   tcpse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   tcpse_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .cmd            (q_rdata),
      .q_pop          (q_pop),
      .timeout_ms     (timeout_ff),
      .rexmit_en      (rexmit_en_ff),
      .rexmit_lim     (rexmit_lim_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_conn_index (rsp_conn_index),
      .rsp_out_flags  (rsp_out_flags),
      .rsp_out_seq    (rsp_out_seq),
      .rsp_out_ack    (rsp_out_ack),
      .rsp_out_len    (rsp_out_len),
      .rsp_peer_addr  (rsp_peer_addr),
      .rsp_peer_port  (rsp_peer_port),
      .rsp_own_port   (rsp_own_port),
      .rsp_aux_flag   (rsp_aux_flag),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== verif/tb.sv =====
// -----------------------------------------------------------------------------
// tb: self-checking testbench of the TCP connection state engine
// A connection-table predictor and a queue of expected result transactions
// check every result. Directed handshakes, data, closes, resets and timeouts
// come first, then random connection traffic mixed with noise, under several
// register settings and random idling and stalling on both channels.
// -----------------------------------------------------------------------------
module tb;
   import tcpse_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      op_type      op;
      logic [31:0] now;
      logic [31:0] dst;
      logic [31:0] src;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [5:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] len;
      logic        acc;
      logic [1:0]  cid;
   } seg_req_type;

   typedef struct {
      kind_type    kind;
      logic [1:0]  idx;
      logic [5:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] len;
      logic [31:0] addr;
      logic [15:0] rport;
      logic [15:0] lport;
      logic        aux;
      logic        last;
   } conn_event_type;

   // connection table predictor and expected-result queue
   class conn_scoreboard;
      logic [31:0] local_ip = 0;
      logic [15:0] timeout_ms = 1000;
      logic        rexmit_en = 1;
      logic [2:0]  rexmit_lim = 5;
      conn_state_type st[CONN_NUM];
      logic [31:0] ev_time[CONN_NUM], snd_seq[CONN_NUM], rcv_ack[CONN_NUM];
      logic [31:0] sav_seq[CONN_NUM], rip[CONN_NUM];
      logic [15:0] rport[CONN_NUM], lport[CONN_NUM];
      logic [2:0]  retries[CONN_NUM];
      logic        fin_acked[CONN_NUM];
      conn_event_type expected_events[$];
      int errors = 0, checked = 0, segs_seen = 0;

      function new();
         for (int i = 0; i < CONN_NUM; i++) begin
            st[i] = CS_CLOSED; ev_time[i] = 0; retries[i] = 0; fin_acked[i] = 0;
         end
      endfunction

      function void configure(logic [1:0] idx, logic [31:0] v);
         case (idx)
            CSR_LOCAL_IP:   local_ip = v;
            CSR_TIMEOUT:    timeout_ms = v[15:0];
            CSR_REXMIT_EN:  rexmit_en = v[0];
            CSR_REXMIT_LIM: rexmit_lim = v[2:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void push(kind_type k, int id, logic [5:0] fl, logic [31:0] sq,
                         logic [31:0] ak, logic [15:0] ln, logic ax, bit conn);
         conn_event_type e;
         e.kind = k; e.idx = id[1:0]; e.flags = fl; e.seq = sq; e.ack = ak;
         e.len = ln; e.aux = ax; e.last = 0;
         e.addr  = conn ? rip[id] : 32'd0;
         e.rport = conn ? rport[id] : 16'd0;
         e.lport = conn ? lport[id] : 16'd0;
         expected_events.push_back(e);
      endfunction

      function void xmit(int id, logic [5:0] fl, logic [15:0] ln);
         push(K_SEGMENT, id, fl, snd_seq[id], rcv_ack[id], ln, 0, 1);
         snd_seq[id] += ln;
         if (fl & (FL_SYN | FL_FIN)) snd_seq[id] += 1;
      endfunction

      function void notify(kind_type k, int id, logic [15:0] ln, logic ax);
         push(k, id, 0, 0, 0, ln, ax, 1);
      endfunction

      function int free_slot();
         for (int i = 0; i < CONN_NUM; i++)
            if (st[i] == CS_CLOSED) return i;
         return -1;
      endfunction

      function void open_entry(int id, conn_state_type s, logic [31:0] now,
                               logic [31:0] ak, logic [31:0] a, logic [15:0] rp,
                               logic [15:0] lp);
         logic [31:0] isn;
         isn = now + (now << 16);
         st[id] = s; ev_time[id] = now; snd_seq[id] = isn; sav_seq[id] = isn;
         rcv_ack[id] = ak; rip[id] = a; rport[id] = rp; lport[id] = lp;
         fin_acked[id] = 0; retries[id] = 0;
      endfunction

      function void segment(seg_req_type r);
         logic [5:0] fl;
         int id;
         fl = r.flags & FL_SEG_MASK;
         id = -1;
         if (r.dst != local_ip) return;
         for (int i = 0; i < CONN_NUM; i++)
            if (id < 0 && st[i] != CS_CLOSED && rip[i] == r.src &&
                rport[i] == r.sport && lport[i] == r.dport) id = i;
         // unmatched: only a bare SYN opens a passive connection
         if (id < 0) begin
            if (fl == FL_SYN) begin
               id = free_slot();
               if (id >= 0) begin
                  open_entry(id, CS_SYN_RCVD, r.now, r.seq + 1, r.src, r.sport, r.dport);
                  xmit(id, FL_SYN | FL_ACK, 0);
               end
            end
            return;
         end
         if (fl & FL_RST) begin
            if (st[id] == CS_ESTAB || st[id] == CS_FIN_WAIT) notify(K_CLOSED, id, 0, 1);
            st[id] = CS_CLOSED;
            return;
         end
         if (r.seq != rcv_ack[id] || r.ack != snd_seq[id] || !(fl & FL_ACK)) return;
         sav_seq[id] = snd_seq[id];
         retries[id] = 0;
         rcv_ack[id] += r.len;
         if (fl & (FL_FIN | FL_SYN)) rcv_ack[id] += 1;
         ev_time[id] = r.now;
         case (st[id])
            CS_SYN_SENT: begin
               if (fl != (FL_SYN | FL_ACK)) st[id] = CS_CLOSED;
               else begin
                  xmit(id, FL_ACK, 0);
                  st[id] = CS_ESTAB;
                  notify(K_READ, id, 0, 0);
               end
            end
            CS_SYN_RCVD: begin
               if (fl != FL_ACK) st[id] = CS_CLOSED;
               else begin
                  st[id] = CS_ESTAB;
                  notify(K_READ, id, 0, 0);
               end
            end
            CS_ESTAB: begin
               if (fl == (FL_FIN | FL_ACK)) begin
                  if (r.len != 0) notify(K_DELIVER, id, r.len, 0);
                  xmit(id, FL_FIN | FL_ACK, 0);
                  st[id] = CS_CLOSED;
                  notify(K_CLOSED, id, 0, 0);
               end else if (fl == FL_ACK) begin
                  if (r.len != 0) notify(K_DELIVER, id, r.len, 0);
                  notify(K_READ, id, 0, 0);
                  if (r.len != 0) xmit(id, FL_ACK, 0);
               end
            end
            CS_FIN_WAIT: begin
               if (fl == (FL_FIN | FL_ACK)) begin
                  if (r.len != 0) notify(K_DELIVER, id, r.len, 0);
                  xmit(id, FL_ACK, 0);
                  st[id] = CS_CLOSED;
                  notify(K_CLOSED, id, 0, 0);
               end else if (fl == FL_ACK && r.len != 0) begin
                  notify(K_DELIVER, id, r.len, 0);
                  xmit(id, FL_ACK, 0);
                  fin_acked[id] = 1;
               end
            end
            default: ;
         endcase
      endfunction

      function void tick(logic [31:0] now);
         logic [31:0] age;
         for (int u = 0; u < CONN_NUM; u++) begin
            age = now - ev_time[u];
            if (st[u] == CS_CLOSED || age <= {16'd0, timeout_ms}) continue;
            if (!rexmit_en || retries[u] > rexmit_lim) begin
               st[u] = CS_CLOSED;
               notify(K_CLOSED, u, 0, 1);
               continue;
            end
            ev_time[u] = now;
            if (retries[u] != 3'd7) retries[u]++;
            snd_seq[u] = sav_seq[u];
            case (st[u])
               CS_SYN_SENT: xmit(u, FL_SYN, 0);
               CS_SYN_RCVD: xmit(u, FL_SYN | FL_ACK, 0);
               CS_FIN_WAIT: begin
                  if (!fin_acked[u]) begin
                     st[u] = CS_ESTAB;
                     notify(K_READ, u, 0, 1);
                  end
                  xmit(u, FL_ACK, 0);
               end
               CS_ESTAB: begin
                  notify(K_READ, u, 0, 1);
                  xmit(u, FL_ACK, 0);
               end
               default: ;
            endcase
         end
      endfunction

      // accepted request transaction: predict all its results
      function void note_request(seg_req_type r);
         int id, done_idx;
         logic done_aux;
         logic [5:0] fl;
         done_idx = 0; done_aux = 0;
         case (r.op)
            OP_SEG: segment(r);
            OP_OPEN: begin
               id = free_slot();
               if (id < 0) done_aux = 1;
               else begin
                  open_entry(id, CS_SYN_SENT, r.now, 0, r.src, r.sport, r.dport);
                  xmit(id, FL_SYN, 0);
                  done_idx = id;
               end
            end
            OP_SEND: begin
               if (st[r.cid] == CS_ESTAB) begin
                  fl = FL_ACK | (r.flags & FL_PSH);
                  if (r.flags & FL_FIN) begin
                     fl |= FL_FIN;
                     st[r.cid] = CS_FIN_WAIT;
                  end
                  xmit(r.cid, fl, r.len);
               end
            end
            default: tick(r.now);
         endcase
         push(K_DONE, done_idx, 0, 0, 0, 0, done_aux, 0);
         expected_events[$].last = 1;
      endfunction

      function bit field_ok(string name, logic [31:0] e, logic [31:0] a);
         if (e === a) return 1;
         $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, e, a);
         return 0;
      endfunction

      function void check_result(conn_event_type a);
         conn_event_type e;
         bit ok;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected result transaction, kind %0d", $time, a.kind);
            errors++;
            return;
         end
         e = expected_events.pop_front();
         checked++;
         if (a.kind == K_SEGMENT) segs_seen++;
         ok = field_ok("kind", e.kind, a.kind);
         ok &= field_ok("conn_index", e.idx, a.idx);
         ok &= field_ok("out_flags", e.flags, a.flags);
         ok &= field_ok("out_seq", e.seq, a.seq);
         ok &= field_ok("out_ack", e.ack, a.ack);
         ok &= field_ok("out_len", e.len, a.len);
         ok &= field_ok("peer_addr", e.addr, a.addr);
         ok &= field_ok("peer_port", e.rport, a.rport);
         ok &= field_ok("own_port", e.lport, a.lport);
         ok &= field_ok("aux_flag", e.aux, a.aux);
         ok &= field_ok("last", e.last, a.last);
         if (!ok) errors++;
      endfunction
   endclass

   typedef enum int {
      G_OPEN, G_SYNACK, G_PASSIVE, G_ACK_RCVD, G_DATA, G_FIN_PEER, G_SEND,
      G_SEND_FIN, G_TICK, G_TIMEOUT, G_RST, G_WRONG_SEQ, G_BAD_SEND, G_NOISE
   } gen_kind_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int RANDOM_ITEMS   = 220;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_we = 0;
   logic req_stall, rsp_valid;
   logic [1:0]  req_opcode = 0, req_conn_id = 0, csr_index = 0;
   logic [31:0] req_now_ms = 0, req_dst_addr = 0, req_src_addr = 0;
   logic [31:0] req_seg_seq = 0, req_seg_ack = 0, csr_wdata = 0;
   logic [15:0] req_src_port = 0, req_dst_port = 0, req_payload_len = 0;
   logic [5:0]  req_seg_flags = 0;
   logic        req_accept_ok = 0;
   logic [2:0]  rsp_kind;
   logic [1:0]  rsp_conn_index;
   logic [5:0]  rsp_out_flags;
   logic [31:0] rsp_out_seq, rsp_out_ack, rsp_peer_addr;
   logic [15:0] rsp_out_len, rsp_peer_port, rsp_own_port;
   logic        rsp_aux_flag, rsp_last;

   conn_scoreboard sb = new();
   logic [31:0] cur_now = 32'hFFFF_FF00;
   int idle_cycles = 0, items_sent = 0, settings_used = 0;
   bit hold_req = 0;

   tcp_connection_state_engine DUT (.*);

   initial forever #2 clock = ~clock;

   // random gap: mostly none or short, a few long
   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function int find_conn(conn_state_type s);
      int hits[$];
      for (int i = 0; i < CONN_NUM; i++)
         if (sb.st[i] == s) hits.push_back(i);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   function seg_req_type seg_to(int id, logic [5:0] fl);
      seg_req_type r;
      r.op = OP_SEG; r.now = cur_now; r.dst = sb.local_ip; r.src = sb.rip[id];
      r.sport = sb.rport[id]; r.dport = sb.lport[id]; r.flags = fl;
      r.seq = sb.rcv_ack[id]; r.ack = sb.snd_seq[id]; r.len = 0;
      r.acc = 0; r.cid = 2'($urandom_range(0, 3));
      return r;
   endfunction

   function logic [15:0] data_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 16'd0;
      if (r == 9) return 16'hFFFF;
      return 16'($urandom_range(1, 1500));
   endfunction

   // build one request from the current predicted table
   function seg_req_type make_request(gen_kind_type g);
      seg_req_type r;
      int id;
      cur_now += $urandom_range(0, 20);
      r.op = op_type'($urandom_range(0, 3)); r.now = cur_now;
      r.dst = $urandom; r.src = $urandom; r.sport = 16'($urandom); r.dport = 16'($urandom);
      r.flags = 6'($urandom); r.seq = $urandom; r.ack = $urandom; r.len = 16'($urandom);
      r.acc = 1'($urandom); r.cid = 2'($urandom);
      case (g)
         G_OPEN: r.op = OP_OPEN;
         G_PASSIVE: begin
            r.op = OP_SEG; r.dst = sb.local_ip; r.flags = FL_SYN | (6'($urandom) & 6'h28);
         end
         G_SYNACK, G_ACK_RCVD, G_DATA, G_FIN_PEER, G_RST, G_WRONG_SEQ: begin
            case (g)
               G_SYNACK:   id = find_conn(CS_SYN_SENT);
               G_ACK_RCVD: id = find_conn(CS_SYN_RCVD);
               G_DATA, G_FIN_PEER: begin
                  id = find_conn(CS_ESTAB);
                  if (id < 0 || $urandom_range(0, 2) == 0) begin
                     if (find_conn(CS_FIN_WAIT) >= 0) id = find_conn(CS_FIN_WAIT);
                  end
               end
               default: begin
                  id = $urandom_range(0, CONN_NUM - 1);
                  if (sb.st[id] == CS_CLOSED) id = -1;
               end
            endcase
            if (id < 0) r.op = OP_OPEN;
            else begin
               case (g)
                  G_SYNACK:   r = seg_to(id, FL_SYN | FL_ACK);
                  G_ACK_RCVD: r = seg_to(id, FL_ACK | (6'($urandom) & 6'h28));
                  G_DATA: begin
                     r = seg_to(id, FL_ACK | (6'($urandom) & 6'h28));
                     r.len = data_len();
                  end
                  G_FIN_PEER: begin
                     r = seg_to(id, FL_FIN | FL_ACK);
                     r.len = data_len();
                  end
                  G_RST: r = seg_to(id, FL_RST | (6'($urandom) & 6'h3B));
                  default: begin
                     r = seg_to(id, $urandom_range(0, 1) ? FL_ACK : 6'($urandom));
                     if ($urandom_range(0, 1)) r.seq += 1; else r.ack -= 1;
                     r.len = data_len();
                  end
               endcase
            end
         end
         G_SEND, G_SEND_FIN: begin
            id = find_conn(CS_ESTAB);
            r.op = OP_SEND;
            if (id >= 0) r.cid = 2'(id);
            r.flags = (g == G_SEND_FIN) ? (r.flags | FL_FIN) : (r.flags & ~FL_FIN);
            r.len = data_len();
         end
         G_BAD_SEND: begin
            r.op = OP_SEND;
            id = find_conn(CS_SYN_SENT);
            if (id < 0) id = find_conn(CS_CLOSED);
            if (id >= 0) r.cid = 2'(id);
         end
         G_TICK: r.op = OP_TICK;
         G_TIMEOUT: begin
            r.op = OP_TICK;
            cur_now += {16'd0, sb.timeout_ms} + $urandom_range(1, 30);
            r.now = cur_now;
         end
         default: begin
            if ($urandom_range(0, 1)) r.dst = sb.local_ip;
         end
      endcase
      return r;
   endfunction

   function gen_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return G_OPEN;
      if (r < 20) return G_SYNACK;
      if (r < 27) return G_PASSIVE;
      if (r < 34) return G_ACK_RCVD;
      if (r < 48) return G_DATA;
      if (r < 53) return G_FIN_PEER;
      if (r < 63) return G_SEND;
      if (r < 67) return G_SEND_FIN;
      if (r < 74) return G_TICK;
      if (r < 81) return G_TIMEOUT;
      if (r < 84) return G_RST;
      if (r < 88) return G_WRONG_SEQ;
      if (r < 90) return G_BAD_SEND;
      return G_NOISE;
   endfunction

   // offer one request transaction and wait for it to be taken
   task automatic send_request(seg_req_type r);
      repeat (gap_len()) @(negedge clock);
      req_valid = 1; req_opcode = r.op; req_now_ms = r.now; req_dst_addr = r.dst;
      req_src_addr = r.src; req_src_port = r.sport; req_dst_port = r.dport;
      req_seg_flags = r.flags; req_seg_seq = r.seq; req_seg_ack = r.ack;
      req_payload_len = r.len; req_accept_ok = r.acc; req_conn_id = r.cid;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      items_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      sb.configure(idx, v);
   endtask

   task automatic apply_settings(logic [31:0] ip, logic [15:0] tmo, logic en,
                                 logic [2:0] lim);
      wait_idle();
      write_csr(CSR_LOCAL_IP, ip);
      write_csr(CSR_TIMEOUT, {16'd0, tmo});
      write_csr(CSR_REXMIT_EN, {31'd0, en});
      write_csr(CSR_REXMIT_LIM, {29'd0, lim});
      settings_used++;
   endtask

   // result channel: random stall, plus one long hold when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end else if ($urandom_range(0, 99) < 75) begin
            rsp_stall = 0;
         end else begin
            rsp_stall = 1;
            repeat (gap_len()) @(negedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      conn_event_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a.kind = kind_type'(rsp_kind); a.idx = rsp_conn_index; a.flags = rsp_out_flags;
         a.seq = rsp_out_seq; a.ack = rsp_out_ack; a.len = rsp_out_len;
         a.addr = rsp_peer_addr; a.rport = rsp_peer_port; a.lport = rsp_own_port;
         a.aux = rsp_aux_flag; a.last = rsp_last;
         sb.check_result(a);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      gen_kind_type directed[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: handshakes, data, closes, reset, timeouts, table full
      apply_settings(32'h0A00_0001, 16'd100, 1'b1, 3'd0);
      directed = '{G_OPEN, G_SYNACK, G_DATA, G_SEND, G_SEND_FIN, G_DATA, G_FIN_PEER,
                   G_PASSIVE, G_ACK_RCVD, G_DATA, G_RST, G_BAD_SEND, G_OPEN, G_OPEN,
                   G_OPEN, G_OPEN, G_OPEN, G_PASSIVE, G_NOISE, G_WRONG_SEQ,
                   G_TIMEOUT, G_TIMEOUT, G_TIMEOUT, G_TICK};
      foreach (directed[i]) send_request(make_request(directed[i]));

      // random traffic over several register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: apply_settings(32'h0000_0000, 16'd1, 1'b0, 3'd6);
            1: apply_settings(32'hFFFF_FFFF, 16'd65535, 1'b1, 3'd6);
            2: apply_settings($urandom, 16'd200, 1'b1, 3'd2);
            3: apply_settings($urandom, 16'd50, 1'b0, 3'd0);
            default: apply_settings($urandom, 16'd500, 1'b1, 3'd5);
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
            if (ph == 1 && n == 10) hold_req = 1;
            if (ph == 2 && n == 20) wait_idle();
            send_request(make_request(pick_kind()));
         end
      end

      wait_idle();
      $display("Covered %0d request transactions under %0d register settings;",
               items_sent, settings_used);
      $display("%0d result transactions checked, %0d of them segments to send.",
               sb.checked, sb.segs_seen);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tcpse_pkg.sv
rtl/tcpse_front.sv
rtl/tcpse_queue.sv
rtl/tcpse_engine.sv
rtl/tcp_connection_state_engine.sv
verif/tb.sv
